[design/asc_pkg.sv]
// Package with the size-class constants shared by the rounding logic.
package asc_pkg;

  // Quantum and group shape of the size classes.
  localparam int unsigned LgQuantum = 4;
  localparam int unsigned LgNGroup  = 2;
  // Nonzero requests up to this size all map to the single tiny class.
  localparam int unsigned TinyLimit = 8;
  localparam int unsigned TinyClass = 8;
  // Below this ceiling log2 of the size the step stays at the quantum and the base is zero.
  localparam int unsigned LgFirstGroup = LgQuantum + LgNGroup + 1;

endpackage

[design/asc_if.sv]
// Valid/ready channel interfaces for requests and class results.
interface asc_req_if #(
  parameter int unsigned SIZE_WIDTH = 48
);
  logic                  valid;
  logic                  ready;
  logic [SIZE_WIDTH-1:0] request_size;

  modport source (output valid, output request_size, input ready);
  modport sink   (input valid, input request_size, output ready);
endinterface

interface asc_rsp_if #(
  parameter int unsigned SIZE_WIDTH = 48
);
  logic                valid;
  logic                ready;
  logic [SIZE_WIDTH:0] class_size;

  modport source (output valid, output class_size, input ready);
  modport sink   (input valid, input class_size, output ready);
endinterface

[design/asc_round.sv]
// Combinational rounding of a request size up to its size class.
module asc_round
  import asc_pkg::*;
#(
  parameter int unsigned SIZE_WIDTH = 48
) (
  input  logic [SIZE_WIDTH-1:0] size_i,
  output logic [SIZE_WIDTH:0]   class_o
);

  localparam int unsigned FW = $clog2(SIZE_WIDTH + 1);

  logic [SIZE_WIDTH:0]   twice_m1;
  logic [SIZE_WIDTH-1:0] size_m1;
  logic [FW-1:0]         lg_f;
  logic [FW-1:0]         lg_step;
  logic                  big_group;
  logic [1:0]            sub_class;
  logic [2:0]            mult;
  logic [SIZE_WIDTH:0]   base;
  logic [SIZE_WIDTH:0]   offset;
  logic [SIZE_WIDTH-1:0] shifted;

  assign twice_m1 = {size_i, 1'b0} - {{SIZE_WIDTH{1'b0}}, 1'b1};
  assign size_m1  = size_i - {{(SIZE_WIDTH-1){1'b0}}, 1'b1};

  // Priority encode of the highest set bit of 2*size-1.
  always_comb begin
    lg_f = '0;
    for (int i = 0; i <= SIZE_WIDTH; i++) begin
      if (twice_m1[i]) begin
        lg_f = FW'(i);
      end
    end
  end

  assign big_group = (lg_f >= FW'(LgFirstGroup));
  assign lg_step   = big_group ? (lg_f - FW'(LgNGroup + 1)) : FW'(LgQuantum);
  assign shifted   = size_m1 >> lg_step;
  assign sub_class = shifted[1:0];
  assign mult      = {1'b0, sub_class} + 3'd1;
  assign offset    = {{(SIZE_WIDTH-2){1'b0}}, mult} << lg_step;
  assign base      = big_group ? ({{SIZE_WIDTH{1'b0}}, 1'b1} << (lg_f - FW'(1))) : '0;

  always_comb begin
    if (size_i == '0) begin
      class_o = '0;
    end else if (size_i <= SIZE_WIDTH'(TinyLimit)) begin
      class_o = (SIZE_WIDTH + 1)'(TinyClass);
    end else begin
      class_o = base + offset;
    end
  end

endmodule

[design/alloc_size_class_round_core.sv]
// Top level: registered size-class rounding with input and result stages.
//
//   channel | dir | payload                       | handshake
//   req_i   | in  | request_size [SIZE_WIDTH-1:0]  | valid/ready
//   rsp_o   | out | class_size   [SIZE_WIDTH:0]    | valid/ready
//
// A word is taken into the input register, rounded by one combinational
// pass and captured in the result register.
// One word is accepted every cycle while the result side keeps taking words.
// When the result side stalls, both stages fill and ready drops after them.
// Reset clears only the stage valid flags.
module alloc_size_class_round_core
  import asc_pkg::*;
#(
  parameter int unsigned SIZE_WIDTH = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  asc_req_if.sink       req_i,
  asc_rsp_if.source     rsp_o
);

  logic                  in_valid_q;
  logic [SIZE_WIDTH-1:0] in_size_q;
  logic                  out_valid_q;
  logic [SIZE_WIDTH:0]   out_class_q;
  logic [SIZE_WIDTH:0]   class_d;
  logic                  out_free;
  logic                  in_free;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign in_free     = !in_valid_q || out_free;
  assign req_i.ready = in_free;

  asc_round #(
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_round (
    .size_i (in_size_q),
    .class_o(class_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid_q <= req_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && req_i.valid) begin
      in_size_q <= req_i.request_size;
    end
    if (out_free && in_valid_q) begin
      out_class_q <= class_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.class_size = out_class_q;

endmodule
